// ----- hdl/h2r_pkg.sv -----
// ----------------------------------------------------------------------------
// h2r_pkg
// Shared types and constants for the HSL to RGB converter pipeline.
// ----------------------------------------------------------------------------
package h2r_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_STAGES    = 5;
  localparam int NUM_CHAN      = 3;

  localparam int CH_R = 0;
  localparam int CH_G = 1;
  localparam int CH_B = 2;

  // hue ramp segment: rising edge, plateau at q, falling edge, floor at p
  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_FLAT,
    SEG_FALL,
    SEG_LOW
  } seg_t;

endpackage

// ----- hdl/hsl_to_rgb_converter.sv -----
// Pipeline: each accepted transaction passes through stages 1 to 5 in order.
// Throughput: one transaction per cycle while out_stall is low; five register
//   stages, each stage moves whenever it is empty or the stage after it moves.
// Reset: synchronous active-low rst_n clears all stage valid bits; data
//   registers are not reset.
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// HSL to 8-bit RGB conversion pipeline: hue segmenting and q/p in stages
// 1-2, hue ramp in stages 3-4, byte scaling in stage 5.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter #(
  parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FRAC_BITS-1:0] in_hue,
  input  logic [FRAC_BITS:0]   in_saturation,
  input  logic [FRAC_BITS:0]   in_lightness,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue
);

  localparam int NS = h2r_pkg::NUM_STAGES;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;
  logic [NS-1:0] rdy;

  h2r_pkg::seg_t               seg   [h2r_pkg::NUM_CHAN];
  logic [FRAC_BITS:0]          w     [h2r_pkg::NUM_CHAN];
  logic signed [FRAC_BITS+3:0] q;
  logic signed [FRAC_BITS+3:0] p;
  logic signed [FRAC_BITS+4:0] diff;
  logic [FRAC_BITS:0]          l2;
  logic                        zero2;
  logic signed [FRAC_BITS+4:0] chan  [h2r_pkg::NUM_CHAN];
  logic [7:0]                  bytes [h2r_pkg::NUM_CHAN];

  always_comb begin
    rdy[NS-1] = !vld_r[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NS; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NS-1];

  h2r_hue_seg #(.FRAC_BITS(FRAC_BITS)) u_hue_seg (
    .clk   (clk),
    .ld1   (rdy[0]),
    .ld2   (rdy[1]),
    .hue   (in_hue),
    .seg_o (seg),
    .w_o   (w)
  );

  h2r_qp_calc #(.FRAC_BITS(FRAC_BITS)) u_qp_calc (
    .clk        (clk),
    .ld1        (rdy[0]),
    .ld2        (rdy[1]),
    .saturation (in_saturation),
    .lightness  (in_lightness),
    .q_o        (q),
    .p_o        (p),
    .diff_o     (diff),
    .l_o        (l2),
    .zero_o     (zero2)
  );

  h2r_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp (
    .clk    (clk),
    .ld3    (rdy[2]),
    .ld4    (rdy[3]),
    .seg_i  (seg),
    .w_i    (w),
    .q_i    (q),
    .p_i    (p),
    .diff_i (diff),
    .l_i    (l2),
    .zero_i (zero2),
    .chan_o (chan)
  );

  h2r_byte_out #(.FRAC_BITS(FRAC_BITS)) u_byte_out (
    .clk    (clk),
    .ld5    (rdy[4]),
    .chan_i (chan),
    .byte_o (bytes)
  );

  assign out_red   = bytes[h2r_pkg::CH_R];
  assign out_green = bytes[h2r_pkg::CH_G];
  assign out_blue  = bytes[h2r_pkg::CH_B];

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted transaction did not enter stage 1");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (&vld_r) && out_stall |-> in_stall)
    else $error("full stalled pipeline took a transaction");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NS-2] && !rdy[NS-1] |=> vld_r[NS-2] && vld_r[NS-1])
    else $error("blocked stage dropped its transaction");

  a_bubble_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !(&vld_r) |-> !in_stall)
    else $error("pipeline with a free stage stalled input");
`endif

endmodule

// ----- hdl/h2r_hue_seg.sv -----
// ----------------------------------------------------------------------------
// h2r_hue_seg
// Hue path, stages 1 and 2: scales hue by six, offsets and wraps the ramp
// argument per channel, and picks the ramp segment and its slope weight.
// ----------------------------------------------------------------------------
module h2r_hue_seg #(
  parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 ld1,
  input  logic                 ld2,
  input  logic [FRAC_BITS-1:0] hue,
  output h2r_pkg::seg_t        seg_o [h2r_pkg::NUM_CHAN],
  output logic [FRAC_BITS:0]   w_o   [h2r_pkg::NUM_CHAN]
);

  localparam int TW = FRAC_BITS + 3;
  localparam int WW = FRAC_BITS + 1;
  localparam logic [TW-1:0] T1 = TW'(1) << FRAC_BITS;
  localparam logic [TW-1:0] T2 = TW'(2) << FRAC_BITS;
  localparam logic [TW-1:0] T3 = TW'(3) << FRAC_BITS;
  localparam logic [TW-1:0] T4 = TW'(4) << FRAC_BITS;

  logic [TW-1:0]  h6;
  logic [TW-1:0]  t     [h2r_pkg::NUM_CHAN];
  h2r_pkg::seg_t  seg_nxt [h2r_pkg::NUM_CHAN];
  logic [WW-1:0]  w_nxt   [h2r_pkg::NUM_CHAN];
  h2r_pkg::seg_t  seg1_r  [h2r_pkg::NUM_CHAN];
  logic [WW-1:0]  w1_r    [h2r_pkg::NUM_CHAN];
  h2r_pkg::seg_t  seg2_r  [h2r_pkg::NUM_CHAN];
  logic [WW-1:0]  w2_r    [h2r_pkg::NUM_CHAN];

  always_comb begin
    h6 = (TW'(hue) << 2) + (TW'(hue) << 1);
    t[h2r_pkg::CH_R] = (h6 > T4) ? h6 - T4 : h6 + T2;
    t[h2r_pkg::CH_G] = h6;
    t[h2r_pkg::CH_B] = (h6 < T2) ? h6 + T4 : h6 - T2;
    for (int k = 0; k < h2r_pkg::NUM_CHAN; k++) begin
      if (t[k] < T1) begin
        seg_nxt[k] = h2r_pkg::SEG_RISE;
        w_nxt[k]   = WW'(t[k]);
      end else if (t[k] < T3) begin
        seg_nxt[k] = h2r_pkg::SEG_FLAT;
        w_nxt[k]   = '0;
      end else if (t[k] < T4) begin
        seg_nxt[k] = h2r_pkg::SEG_FALL;
        w_nxt[k]   = WW'(T4 - t[k]);
      end else begin
        seg_nxt[k] = h2r_pkg::SEG_LOW;
        w_nxt[k]   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      seg1_r <= seg_nxt;
      w1_r   <= w_nxt;
    end
    if (ld2) begin
      seg2_r <= seg1_r;
      w2_r   <= w1_r;
    end
  end

  assign seg_o = seg2_r;
  assign w_o   = w2_r;

endmodule

// ----- hdl/h2r_qp_calc.sv -----
// ----------------------------------------------------------------------------
// h2r_qp_calc
// Stages 1 and 2: one multiply of lightness by (1+s) or s, then q, p and
// the ramp span q - p.
// ----------------------------------------------------------------------------
module h2r_qp_calc #(
  parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        ld1,
  input  logic                        ld2,
  input  logic [FRAC_BITS:0]          saturation,
  input  logic [FRAC_BITS:0]          lightness,
  output logic signed [FRAC_BITS+3:0] q_o,
  output logic signed [FRAC_BITS+3:0] p_o,
  output logic signed [FRAC_BITS+4:0] diff_o,
  output logic [FRAC_BITS:0]          l_o,
  output logic                        zero_o
);

  localparam int UW = FRAC_BITS + 1;
  localparam int BW = FRAC_BITS + 2;
  localparam int MW = UW + BW;
  localparam int QW = FRAC_BITS + 4;
  localparam int DW = FRAC_BITS + 5;
  localparam logic [UW-1:0] HALF = UW'(1) << (FRAC_BITS - 1);
  localparam logic [BW-1:0] ONE  = BW'(1) << FRAC_BITS;

  logic                 lo;
  logic [BW-1:0]        mul_b;
  logic [MW-1:0]        prod_nxt;
  logic [MW-1:0]        prod1_r;
  logic [UW-1:0]        l1_r;
  logic [UW-1:0]        s1_r;
  logic                 lo1_r;
  logic                 zero1_r;
  logic [QW-1:0]        q_u;
  logic signed [QW-1:0] q_nxt;
  logic signed [QW-1:0] p_nxt;
  logic signed [DW-1:0] diff_nxt;
  logic signed [QW-1:0] q2_r;
  logic signed [QW-1:0] p2_r;
  logic signed [DW-1:0] diff2_r;
  logic [UW-1:0]        l2_r;
  logic                 zero2_r;

  always_comb begin
    lo       = (lightness < HALF);
    mul_b    = lo ? ONE + BW'(saturation) : BW'(saturation);
    prod_nxt = MW'(lightness) * MW'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      prod1_r <= prod_nxt;
      l1_r    <= lightness;
      s1_r    <= saturation;
      lo1_r   <= lo;
      zero1_r <= (saturation == '0);
    end
  end

  always_comb begin
    if (lo1_r) begin
      q_u = QW'(prod1_r >> FRAC_BITS);
    end else begin
      q_u = QW'(l1_r) + QW'(s1_r) - QW'(prod1_r >> FRAC_BITS);
    end
    q_nxt    = $signed(q_u);
    p_nxt    = $signed(QW'(l1_r) << 1) - q_nxt;
    diff_nxt = DW'(q_nxt) - DW'(p_nxt);
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      q2_r    <= q_nxt;
      p2_r    <= p_nxt;
      diff2_r <= diff_nxt;
      l2_r    <= l1_r;
      zero2_r <= zero1_r;
    end
  end

  assign q_o    = q2_r;
  assign p_o    = p2_r;
  assign diff_o = diff2_r;
  assign l_o    = l2_r;
  assign zero_o = zero2_r;

endmodule

// ----- hdl/h2r_ramp.sv -----
// ----------------------------------------------------------------------------
// h2r_ramp
// Stages 3 and 4: slope products per channel, then segment select into the
// channel value (lightness for gray).
// ----------------------------------------------------------------------------
module h2r_ramp #(
  parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        ld3,
  input  logic                        ld4,
  input  h2r_pkg::seg_t               seg_i [h2r_pkg::NUM_CHAN],
  input  logic [FRAC_BITS:0]          w_i   [h2r_pkg::NUM_CHAN],
  input  logic signed [FRAC_BITS+3:0] q_i,
  input  logic signed [FRAC_BITS+3:0] p_i,
  input  logic signed [FRAC_BITS+4:0] diff_i,
  input  logic [FRAC_BITS:0]          l_i,
  input  logic                        zero_i,
  output logic signed [FRAC_BITS+4:0] chan_o [h2r_pkg::NUM_CHAN]
);

  localparam int QW = FRAC_BITS + 4;
  localparam int DW = FRAC_BITS + 5;
  localparam int PW = DW + FRAC_BITS + 2;
  localparam int CW = FRAC_BITS + 5;
  localparam int UW = FRAC_BITS + 1;

  logic signed [PW-1:0] prod_nxt [h2r_pkg::NUM_CHAN];
  logic signed [PW-1:0] prod3_r  [h2r_pkg::NUM_CHAN];
  h2r_pkg::seg_t        seg3_r   [h2r_pkg::NUM_CHAN];
  logic signed [QW-1:0] q3_r;
  logic signed [QW-1:0] p3_r;
  logic [UW-1:0]        l3_r;
  logic                 zero3_r;
  logic signed [CW-1:0] c_nxt    [h2r_pkg::NUM_CHAN];
  logic signed [CW-1:0] c4_r     [h2r_pkg::NUM_CHAN];

  always_comb begin
    for (int k = 0; k < h2r_pkg::NUM_CHAN; k++) begin
      prod_nxt[k] = diff_i * $signed({1'b0, w_i[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      prod3_r <= prod_nxt;
      seg3_r  <= seg_i;
      q3_r    <= q_i;
      p3_r    <= p_i;
      l3_r    <= l_i;
      zero3_r <= zero_i;
    end
  end

  always_comb begin
    for (int k = 0; k < h2r_pkg::NUM_CHAN; k++) begin
      if (zero3_r) begin
        c_nxt[k] = CW'(l3_r);
      end else begin
        case (seg3_r[k]) inside
          h2r_pkg::SEG_RISE,
          h2r_pkg::SEG_FALL: c_nxt[k] = CW'(p3_r) + CW'(prod3_r[k] >>> FRAC_BITS);
          h2r_pkg::SEG_FLAT: c_nxt[k] = CW'(q3_r);
          default:           c_nxt[k] = CW'(p3_r);
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      c4_r <= c_nxt;
    end
  end

  assign chan_o = c4_r;

endmodule

// ----- hdl/h2r_byte_out.sv -----
// ----------------------------------------------------------------------------
// h2r_byte_out
// Stage 5: scales each channel by 255, floors and clamps to 0..255.
// ----------------------------------------------------------------------------
module h2r_byte_out #(
  parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        ld5,
  input  logic signed [FRAC_BITS+4:0] chan_i [h2r_pkg::NUM_CHAN],
  output logic [7:0]                  byte_o [h2r_pkg::NUM_CHAN]
);

  localparam int CW = FRAC_BITS + 5;
  localparam int MW = CW + 8;
  localparam logic signed [MW-1:0] MAX_B = MW'(255);

  logic signed [MW-1:0] m [h2r_pkg::NUM_CHAN];
  logic signed [MW-1:0] v [h2r_pkg::NUM_CHAN];
  logic [7:0]           b_nxt [h2r_pkg::NUM_CHAN];
  logic [7:0]           b5_r  [h2r_pkg::NUM_CHAN];

  always_comb begin
    for (int k = 0; k < h2r_pkg::NUM_CHAN; k++) begin
      m[k] = (MW'(chan_i[k]) <<< 8) - MW'(chan_i[k]);
      v[k] = m[k] >>> FRAC_BITS;
      if (v[k] < 0) begin
        b_nxt[k] = 8'd0;
      end else if (v[k] > MAX_B) begin
        b_nxt[k] = 8'hff;
      end else begin
        b_nxt[k] = v[k][7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld5) begin
      b5_r <= b_nxt;
    end
  end

  assign byte_o = b5_r;

endmodule

// ----- dv/tb_hsl_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// tb_hsl_to_rgb_converter
// Self-checking bench for the HSL to RGB converter. Each accepted color is run
// through a bit-accurate fixed-point model and queued. Every result leaving
// the pipeline is checked channel by channel against the oldest queued color.
// Directed corner cases come first: gray inputs, hue segment edges, and
// saturation or lightness above 1.0. Random colors follow, with gaps and
// stalls on both sides, a back-to-back stretch and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_hsl_to_rgb_converter;

  localparam int FB = h2r_pkg::FRAC_BITS_DEF;
  localparam int UW = FB + 1;
  localparam longint ONE = longint'(1) << FB;
  localparam logic [FB:0] UNIT_ONE = UW'(1) << FB;
  localparam int HOLDOFF_CYCLES = 80;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int DRAIN_CYCLES = 2 * h2r_pkg::NUM_STAGES;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [FB-1:0] hue;
    logic [FB:0]   sat;
    logic [FB:0]   lit;
    rgb_t          rgb;
  } color_xact_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  logic [FB-1:0] in_hue;
  logic [FB:0]   in_saturation;
  logic [FB:0]   in_lightness;
  logic          out_valid;
  logic          out_stall;
  logic [7:0]    out_red;
  logic [7:0]    out_green;
  logic [7:0]    out_blue;

  color_xact_t pending_rgb_q[$];
  bit          idle_en = 1'b0;
  bit          holdoff_req = 1'b0;
  int          error_cnt = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_gray = 0;
  int          stuck_cycles = 0;

  hsl_to_rgb_converter #(.FRAC_BITS(FB)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_lightness  (in_lightness),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic longint floor_scale(longint v);
    return v >>> FB;
  endfunction

  // t6 is six times the turn fraction
  function automatic longint hue_ramp(longint p, longint q, longint t6);
    longint t;
    t = t6;
    if (t < 0) t += 6 * ONE;
    if (t > 6 * ONE) t -= 6 * ONE;
    if (t < ONE) return p + floor_scale((q - p) * t);
    if (t < 3 * ONE) return q;
    if (t < 4 * ONE) return p + floor_scale((q - p) * (4 * ONE - t));
    return p;
  endfunction

  function automatic logic [7:0] chan_byte(longint c);
    longint v;
    v = floor_scale(c * 255);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic rgb_t predict_rgb(logic [FB-1:0] hue, logic [FB:0] sat,
                                       logic [FB:0] lit);
    longint h, s, l, q, p;
    rgb_t   rgb;
    h = longint'(hue);
    s = longint'(sat);
    l = longint'(lit);
    if (s == 0) begin
      rgb.red   = chan_byte(l);
      rgb.green = chan_byte(l);
      rgb.blue  = chan_byte(l);
    end else begin
      if (l < ONE / 2) q = floor_scale(l * (ONE + s));
      else q = l + s - floor_scale(l * s);
      p = 2 * l - q;
      rgb.red   = chan_byte(hue_ramp(p, q, 6 * h + 2 * ONE));
      rgb.green = chan_byte(hue_ramp(p, q, 6 * h));
      rgb.blue  = chan_byte(hue_ramp(p, q, 6 * h - 2 * ONE));
    end
    return rgb;
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_hsl(input logic [FB-1:0] hue, input logic [FB:0] sat,
                          input logic [FB:0] lit);
    bit          taken;
    color_xact_t entry;
    if (idle_en && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_hue        <= hue;
    in_saturation <= sat;
    in_lightness  <= lit;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    entry.hue = hue;
    entry.sat = sat;
    entry.lit = lit;
    entry.rgb = predict_rgb(hue, sat, lit);
    pending_rgb_q.push_back(entry);
    n_sent++;
    if (sat == 0) n_gray++;
  endtask

  function automatic logic [FB:0] rand_unit();
    case ($urandom_range(9))
      0: return '0;
      1: return UNIT_ONE;
      2: return UW'($urandom);
      3: return UW'($urandom_range(255));
      4: return UW'($urandom_range(UNIT_ONE / 2 + 64, UNIT_ONE / 2 - 64));
      default: return UW'($urandom_range(UNIT_ONE));
    endcase
  endfunction

  task automatic send_random_hsl();
    logic [FB-1:0] hue;
    hue = FB'($urandom);
    send_hsl(hue, rand_unit(), rand_unit());
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= idle_en && ($urandom_range(99) < 16);
      end
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic check_chan(string name, logic [7:0] want, logic [7:0] got,
                            color_xact_t x);
    if (got !== want) begin
      $display("%0t: %s mismatch for h=%0d s=%0d l=%0d: expected %0d actual %0d",
               $time, name, x.hue, x.sat, x.lit, want, got);
      error_cnt++;
    end
  endtask

  always @(negedge clk) begin
    color_xact_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rgb_q.size() == 0) begin
        $display("%0t: unexpected transaction r=%0d g=%0d b=%0d",
                 $time, out_red, out_green, out_blue);
        error_cnt++;
      end else begin
        want = pending_rgb_q.pop_front();
        n_checked++;
        check_chan("red", want.rgb.red, out_red, want);
        check_chan("green", want.rgb.green, out_green, want);
        check_chan("blue", want.rgb.blue, out_blue, want);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, stuck_cycles, pending_rgb_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_achromatic();
    send_hsl(0, 0, 0);
    send_hsl(12345, 0, UNIT_ONE);
    send_hsl(16'hffff, 0, '1);
    send_hsl(0, 0, UNIT_ONE / 2);
  endtask

  task automatic test_hue_segments();
    int hues[10] = '{0, 10922, 10923, 21845, 21846, 32768, 43690, 43691,
                     54613, 65535};
    foreach (hues[i]) send_hsl(FB'(hues[i]), UNIT_ONE, UNIT_ONE / 2);
  endtask

  task automatic test_lightness_branch();
    send_hsl(5000, 40000, UNIT_ONE / 2 - 1);
    send_hsl(5000, 40000, UNIT_ONE / 2);
    send_hsl(5000, UNIT_ONE, 0);
  endtask

  // saturation or lightness above 1.0, negative and clipped channels
  task automatic test_out_of_range();
    send_hsl(20000, '1, UNIT_ONE / 4);
    send_hsl(40000, '1, '1);
    send_hsl(0, UNIT_ONE, '1);
    send_hsl(30000, '1, UNIT_ONE);
    send_hsl(16'hffff, 1, 1);
  endtask

  task automatic test_random_gaps(int count);
    idle_en = 1'b1;
    repeat (count) send_random_hsl();
  endtask

  task automatic test_back_to_back(int count);
    idle_en = 1'b0;
    repeat (count) send_random_hsl();
  endtask

  task automatic test_output_holdoff(int count);
    idle_en = 1'b0;
    holdoff_req = 1'b1;
    repeat (count) send_random_hsl();
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_hue        <= '0;
    in_saturation <= '0;
    in_lightness  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_achromatic();
    test_hue_segments();
    test_lightness_branch();
    test_out_of_range();
    test_random_gaps(600);
    test_back_to_back(350);
    test_output_holdoff(100);
    test_random_gaps(400);
    in_valid <= 1'b0;
    idle_en = 1'b0;

    while (pending_rgb_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d colors sent, %0d checked, %0d gray, hue edges and over-range",
             n_sent, n_checked, n_gray);
    $display("input gaps, output stalls, back-to-back run and a %0d-cycle hold-off",
             HOLDOFF_CYCLES);
    if (error_cnt == 0 && pending_rgb_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/h2r_pkg.sv
hdl/h2r_hue_seg.sv
hdl/h2r_qp_calc.sv
hdl/h2r_ramp.sv
hdl/h2r_byte_out.sv
hdl/hsl_to_rgb_converter.sv
dv/tb_hsl_to_rgb_converter.sv
